### rtl/ptsc_pkg.sv
package ptsc_pkg;

  // Fixed field widths of the request and response words.
  localparam int KEY_FIELD_W  = 20;
  localparam int SLOT_FIELD_W = 5;
  localparam int PIN_W        = 8;
  localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

  // Request codes. Code 7 has no meaning and is answered as nothing to do.
  localparam logic [2:0] FN_CLEAR     = 3'd0;
  localparam logic [2:0] FN_APPEND    = 3'd1;
  localparam logic [2:0] FN_CLAIM     = 3'd2;
  localparam logic [2:0] FN_LOAD_DONE = 3'd3;
  localparam logic [2:0] FN_PIN       = 3'd4;
  localparam logic [2:0] FN_RELEASE   = 3'd5;
  localparam logic [2:0] FN_CHECK     = 3'd6;
  localparam logic [2:0] FN_UNUSED    = 3'd7;

  // Response status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOTHING     = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_NOT_LOADING = 2'd3;

  typedef enum logic [1:0] {
    SS_FREE    = 2'd0,
    SS_LOADING = 2'd1,
    SS_READY   = 2'd2
  } slot_st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DONE,
    S_LK_RD,
    S_LK_CMP,
    S_CW_RD,
    S_CW_LATCH,
    S_CL_RD,
    S_CL_CMP,
    S_V_CHK,
    S_V_WRD,
    S_V_WCMP,
    S_C_WRITE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]              func;
    logic [KEY_FIELD_W-1:0]  tile_key;
    logic [SLOT_FIELD_W-1:0] slot_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_FIELD_W-1:0] result_slot;
    logic [KEY_FIELD_W-1:0]  result_key;
    logic                    evicted;
  } out_word_t;

endpackage

### rtl/pinned_tile_slot_cache_core.sv
// Clear, append, load done, release and unknown codes go from idle straight to the done state.
// Pin and check walk the tag memory slot by slot, with a read and a compare state per slot.
// A claim walks wanted list against tags and tags against wanted list through one shared
// key comparator; a new word is taken only once the sequencer is back in idle.
// A new word is taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous) frees all slots, zeroes pins and empties the wanted list.
module pinned_tile_slot_cache_core #(
  parameter int SLOT_COUNT = 32,
  parameter int KEY_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptsc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptsc_pkg::out_word_t out_data
);
  import ptsc_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam logic [CW-1:0] N_C = CW'(SLOT_COUNT);

  // Control state.
  seq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;
  logic [CW-1:0] count_r, count_nxt;
  slot_st_t   slot_st_r [SLOT_COUNT];
  logic [PIN_W-1:0] pin_r [SLOT_COUNT];

  // Working registers of the sequencer.
  logic [2:0]    func_r, func_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic          evict_r, evict_nxt;
  out_word_t     res_r, res_nxt;

  // Memories with registered read data.
  logic [KW-1:0] tag_mem_r  [SLOT_COUNT];
  logic [KW-1:0] want_mem_r [SLOT_COUNT];
  logic [KW-1:0] tag_q_r, want_q_r;
  logic          tag_we, tag_re, want_we, want_re;
  logic [SW-1:0] tag_raddr, want_raddr, want_waddr;
  logic [KW-1:0] want_wdata;

  // Slot table update controls.
  logic          st_we, pin_inc, pin_zero, pin_clr_all;
  slot_st_t      st_val;
  logic [SW-1:0] sel_idx;

  logic [KW-1:0] in_key;
  logic [SW-1:0] j_idx, ld_idx;
  logic [31:0]   sidx_w, j_w;
  logic          sidx_ok;
  logic [KW-1:0] cmp_b;
  logic          cmp_eq;
  logic          occupied;

  assign in_key  = in_data.tile_key[KW-1:0];
  assign j_idx   = j_r[SW-1:0];
  assign j_w     = 32'(j_idx);
  assign sidx_w  = 32'(in_data.slot_index);
  assign ld_idx  = sidx_w[SW-1:0];
  assign sidx_ok = (sidx_w < 32'(SLOT_COUNT));

  // The one key comparator, shared by the tag lookups and the wanted-list test.
  assign cmp_b    = (state_r == S_V_WCMP) ? want_q_r : key_r;
  assign cmp_eq   = (tag_q_r == cmp_b);
  assign occupied = (slot_st_r[j_idx] != SS_FREE);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    m_r        <= m_nxt;
    evict_r    <= evict_nxt;
    res_r      <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_st_r[s] <= SS_FREE;
        pin_r[s]     <= '0;
      end
    end else begin
      if (pin_clr_all) begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
          pin_r[s] <= '0;
        end
      end
      if (pin_inc && (pin_r[sel_idx] != PIN_MAX)) begin
        pin_r[sel_idx] <= pin_r[sel_idx] + PIN_W'(1);
      end
      if (pin_zero) begin
        pin_r[sel_idx] <= '0;
      end
      if (st_we) begin
        slot_st_r[sel_idx] <= st_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem_r[j_idx] <= key_r;
    end
    if (tag_re) begin
      tag_q_r <= tag_mem_r[tag_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (want_we) begin
      want_mem_r[want_waddr] <= want_wdata;
    end
    if (want_re) begin
      want_q_r <= want_mem_r[want_raddr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    count_nxt     = count_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    evict_nxt     = evict_r;
    res_nxt       = res_r;
    tag_we        = 1'b0;
    tag_re        = 1'b0;
    tag_raddr     = j_idx;
    want_we       = 1'b0;
    want_re       = 1'b0;
    want_raddr    = i_r[SW-1:0];
    want_waddr    = count_r[SW-1:0];
    want_wdata    = in_key;
    st_we         = 1'b0;
    st_val        = SS_LOADING;
    pin_inc       = 1'b0;
    pin_zero      = 1'b0;
    pin_clr_all   = 1'b0;
    sel_idx       = j_idx;

    case (state_r)
      S_IDLE: begin
        sel_idx = ld_idx;
        if (in_valid) begin
          func_nxt            = in_data.func;
          key_nxt             = in_key;
          i_nxt               = '0;
          j_nxt               = '0;
          m_nxt               = '0;
          res_nxt.status      = ST_NOTHING;
          res_nxt.result_slot = '0;
          res_nxt.result_key  = '0;
          res_nxt.evicted     = 1'b0;
          state_nxt           = S_DONE;
          case (in_data.func)
            FN_CLEAR: begin
              count_nxt      = '0;
              res_nxt.status = ST_OK;
            end
            FN_APPEND: begin
              if (count_r == N_C) begin
                res_nxt.status = ST_FULL;
              end else begin
                want_we        = 1'b1;
                count_nxt      = count_r + CW'(1);
                res_nxt.status = ST_OK;
              end
            end
            FN_CLAIM: begin
              state_nxt = S_CW_RD;
            end
            FN_LOAD_DONE: begin
              if (sidx_ok && (slot_st_r[ld_idx] == SS_LOADING)) begin
                st_we          = 1'b1;
                st_val         = SS_READY;
                res_nxt.status = ST_OK;
              end else begin
                res_nxt.status = ST_NOT_LOADING;
              end
            end
            FN_PIN, FN_CHECK: begin
              state_nxt = S_LK_RD;
            end
            FN_RELEASE: begin
              pin_clr_all    = 1'b1;
              res_nxt.status = ST_OK;
            end
            default: begin
              res_nxt.status = ST_NOTHING;
            end
          endcase
        end
      end

      // Lookup of the request key for pin and check.
      S_LK_RD: begin
        if (j_r == N_C) begin
          state_nxt = S_DONE;
        end else begin
          tag_re    = 1'b1;
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (occupied && cmp_eq) begin
          if (slot_st_r[j_idx] == SS_READY) begin
            res_nxt.status      = ST_OK;
            res_nxt.result_slot = j_w[SLOT_FIELD_W-1:0];
            pin_inc             = (func_r == FN_PIN);
          end
          state_nxt = S_DONE;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_LK_RD;
        end
      end

      // Claim, first half: the first wanted key that no occupied slot holds.
      S_CW_RD: begin
        if (i_r == count_r) begin
          state_nxt = S_DONE;
        end else begin
          want_re   = 1'b1;
          state_nxt = S_CW_LATCH;
        end
      end
      S_CW_LATCH: begin
        key_nxt   = want_q_r;
        j_nxt     = '0;
        state_nxt = S_CL_RD;
      end
      S_CL_RD: begin
        if (j_r == N_C) begin
          j_nxt     = '0;
          state_nxt = S_V_CHK;
        end else begin
          tag_re    = 1'b1;
          state_nxt = S_CL_CMP;
        end
      end
      S_CL_CMP: begin
        if (occupied && cmp_eq) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_CW_RD;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_CL_RD;
        end
      end

      // Claim, second half: the first free slot, or ready, unpinned and not wanted.
      S_V_CHK: begin
        if (j_r == N_C) begin
          state_nxt = S_DONE;
        end else if (slot_st_r[j_idx] == SS_FREE) begin
          evict_nxt = 1'b0;
          state_nxt = S_C_WRITE;
        end else if ((slot_st_r[j_idx] == SS_READY) && (pin_r[j_idx] == '0)) begin
          tag_re    = 1'b1;
          m_nxt     = '0;
          state_nxt = S_V_WRD;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_V_WRD: begin
        want_raddr = m_r[SW-1:0];
        if (m_r == count_r) begin
          evict_nxt = 1'b1;
          state_nxt = S_C_WRITE;
        end else begin
          want_re   = 1'b1;
          state_nxt = S_V_WCMP;
        end
      end
      S_V_WCMP: begin
        if (cmp_eq) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_V_CHK;
        end else begin
          m_nxt     = m_r + CW'(1);
          state_nxt = S_V_WRD;
        end
      end
      S_C_WRITE: begin
        tag_we              = 1'b1;
        st_we               = 1'b1;
        st_val              = SS_LOADING;
        pin_zero            = 1'b1;
        res_nxt.status      = ST_OK;
        res_nxt.result_slot = j_w[SLOT_FIELD_W-1:0];
        res_nxt.result_key  = KEY_FIELD_W'(key_r);
        res_nxt.evicted     = evict_r;
        state_nxt           = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= N_C)
    else $error("wanted list count exceeds the list depth");

  a_cmp_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LK_CMP || state_r == S_CL_CMP || state_r == S_V_WRD ||
     state_r == S_V_WCMP || state_r == S_C_WRITE) |-> (j_r < N_C))
    else $error("slot scan index out of range in a compare state");

  a_claim_loading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C_WRITE) |=> (slot_st_r[$past(j_idx)] == SS_LOADING))
    else $error("claimed slot did not become loading");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("response raised outside the done state");

  a_idle_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_DONE) |=> (state_r != S_IDLE || $past(state_r) == S_DONE))
    else $error("sequencer left a work state without passing through done");

endmodule
